FILE: rtl/core/sensor_measure_alarm_fsm_top_assert.svh
// Assertion macros for the measurement sequencer.
// Used by sensor_measure_alarm_fsm_top; expects clk and rst_n in scope.
`ifndef SENSOR_MEASURE_ALARM_FSM_TOP_ASSERT_SVH
`define SENSOR_MEASURE_ALARM_FSM_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/sma_pkg.sv
// Shared types and codes for the measurement sequencer.
// No dependencies.
`default_nettype none

package sma_pkg;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_START   = 3'd1,
    OP_PROCESS = 3'd2,
    OP_GET     = 3'd3,
    OP_CHECK   = 3'd4
  } op_t;

  localparam logic signed [14:0] TEMP_HIGH_LIMIT_RST = 15'sd3000;
  localparam logic [15:0]        WAIT_MS_RST         = 16'd50;

  localparam logic REG_TEMP_HIGH_LIMIT = 1'b0;
  localparam logic REG_WAIT_MS         = 1'b1;

  typedef struct packed {
    logic signed [14:0] temp_high_limit;
    logic [15:0]        wait_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [31:0]        now_ms;
    logic               driver_ok;
    logic               read_ok;
    logic signed [14:0] temp_in;
    logic [13:0]        humid_in;
  } evt_t;

  typedef struct packed {
    logic [2:0]         fsm_state;
    logic               op_ok;
    logic signed [14:0] temp_out;
    logic [13:0]        humid_out;
    logic               alarm_out;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/sma_cfg.sv
// APB-style configuration registers of the measurement sequencer.
// Depends on sma_pkg.
`default_nettype none

module sma_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output sma_pkg::cfg_t     cfg
);

  sma_pkg::cfg_t cfg_r;
  logic          wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_high_limit <= sma_pkg::TEMP_HIGH_LIMIT_RST;
      cfg_r.wait_ms         <= sma_pkg::WAIT_MS_RST;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        sma_pkg::REG_TEMP_HIGH_LIMIT: cfg_r.temp_high_limit <= cfg_pwdata[14:0];
        sma_pkg::REG_WAIT_MS:         cfg_r.wait_ms         <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      sma_pkg::REG_TEMP_HIGH_LIMIT: cfg_prdata = {17'd0, cfg_r.temp_high_limit};
      sma_pkg::REG_WAIT_MS:         cfg_prdata = {16'd0, cfg_r.wait_ms};
      default:                      cfg_prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/sma_core.sv
// Sequencer state, per-event next-state logic and result register.
// Depends on sma_pkg.
`default_nettype none

module sma_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sma_pkg::cfg_t cfg,
  input  wire logic          evt_vld,
  input  wire sma_pkg::evt_t evt,
  output logic               evt_rdy,
  output logic               res_vld,
  output sma_pkg::res_t      res,
  input  wire logic          res_rdy
);

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_MEASURING = 3'd1,
    MODE_READY     = 3'd2,
    MODE_ALARM     = 3'd3,
    MODE_ERROR     = 3'd4
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic [31:0]        start_time_r, start_time_nxt;
  logic signed [14:0] last_temp_r, last_temp_nxt;
  logic [13:0]        last_humid_r, last_humid_nxt;
  logic               alarm_r, alarm_nxt;
  logic               res_vld_r;
  sma_pkg::res_t      res_r, res_nxt;
  logic [31:0]        elapsed;
  logic               wait_done;
  logic               ok;
  logic               alarm_rep;
  logic               take;

  assign evt_rdy   = !res_vld_r || res_rdy;
  assign take      = evt_vld && evt_rdy;
  assign res_vld   = res_vld_r;
  assign res       = res_r;
  assign elapsed   = evt.now_ms - start_time_r;
  assign wait_done = elapsed >= {16'd0, cfg.wait_ms};

  always_comb begin
    mode_nxt       = mode_r;
    start_time_nxt = start_time_r;
    last_temp_nxt  = last_temp_r;
    last_humid_nxt = last_humid_r;
    alarm_nxt      = alarm_r;
    ok             = 1'b1;
    alarm_rep      = alarm_r;
    case (evt.op)
      sma_pkg::OP_INIT: begin
        if (evt.driver_ok) begin
          mode_nxt  = MODE_IDLE;
          alarm_nxt = 1'b0;
        end else begin
          mode_nxt = MODE_ERROR;
          ok       = 1'b0;
        end
      end
      sma_pkg::OP_START: begin
        if (mode_r == MODE_IDLE) begin
          if (evt.driver_ok) begin
            mode_nxt       = MODE_MEASURING;
            start_time_nxt = evt.now_ms;
          end else begin
            mode_nxt = MODE_ERROR;
          end
        end
      end
      sma_pkg::OP_PROCESS: begin
        if (mode_r == MODE_MEASURING && wait_done) begin
          if (evt.read_ok) begin
            last_temp_nxt  = evt.temp_in;
            last_humid_nxt = evt.humid_in;
            if (evt.temp_in > cfg.temp_high_limit) begin
              mode_nxt  = MODE_ALARM;
              alarm_nxt = 1'b1;
            end else begin
              mode_nxt = MODE_READY;
            end
          end else begin
            mode_nxt = MODE_ERROR;
          end
        end
      end
      sma_pkg::OP_GET: begin
        if (mode_r == MODE_READY || mode_r == MODE_ALARM) begin
          mode_nxt = MODE_IDLE;
        end else begin
          ok = 1'b0;
        end
      end
      sma_pkg::OP_CHECK: begin
        if (alarm_r) begin
          alarm_nxt = 1'b0;
          mode_nxt  = MODE_IDLE;
        end
      end
      default: ;
    endcase
    if (evt.op != sma_pkg::OP_CHECK) begin
      alarm_rep = alarm_nxt;
    end
    res_nxt.fsm_state = mode_nxt;
    res_nxt.op_ok     = ok;
    res_nxt.temp_out  = last_temp_nxt;
    res_nxt.humid_out = last_humid_nxt;
    res_nxt.alarm_out = alarm_rep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      start_time_r <= 32'd0;
      last_temp_r  <= 15'sd0;
      last_humid_r <= 14'd0;
      alarm_r      <= 1'b0;
      res_vld_r    <= 1'b0;
      res_r        <= '0;
    end else begin
      if (take) begin
        mode_r       <= mode_nxt;
        start_time_r <= start_time_nxt;
        last_temp_r  <= last_temp_nxt;
        last_humid_r <= last_humid_nxt;
        alarm_r      <= alarm_nxt;
        res_vld_r    <= 1'b1;
        res_r        <= res_nxt;
      end else if (res_rdy) begin
        res_vld_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sensor_measure_alarm_fsm_top.sv
// Top level of the measurement sequencer: input register, core and config port.
// Depends on sma_pkg, sma_cfg, sma_core and the assertion macro header.
//
// Usage:
//   in_*   : one event per transaction. in_tuser carries the event code, in_tdata
//            the time stamp, driver outcomes and the read sample.
//   out_*  : one result per event, in order: state after the event, success
//            flag, stored temperature and humidity, alarm flag.
//   cfg_*  : APB-style port; 0x0 alarm threshold, 0x4 wait in milliseconds.
//            Write only while no event is in flight.
// Path: the edge that takes an event loads the input register; its result is then
//   registered in the result register, from which it can be taken.
// Throughput: one event per cycle while out_tready stays high; the per-event state
//   update is a single compare-and-update between the input and result registers.
// Reset: synchronous active low; state goes to idle, stored data and alarm
//   flag to zero, registers to their defaults, both channels empty.
// Stall: while out_tready is low the result holds; the input register still
//   takes one more event, then in_tready drops until the result is taken.
`default_nettype none
`include "sensor_measure_alarm_fsm_top_assert.svh"

module sensor_measure_alarm_fsm_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // slave stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [31:0] now_ms, [32] driver_ok, [33] read_ok, [48:34] temp_in,
  // [62:49] humid_in, [63] zero
  input  wire logic [63:0]  in_tdata,
  // [2:0] op
  input  wire logic [2:0]   in_tuser,
  // master stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [2:0] fsm_state, [3] op_ok, [18:4] temp_out, [32:19] humid_out,
  // [33] alarm_out, [39:34] zero
  output logic [39:0]       out_tdata,
  // configuration port
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  sma_pkg::cfg_t cfg;
  sma_pkg::evt_t s1_evt_r;
  logic          s1_vld_r;
  logic          core_rdy;
  logic          s1_move;
  sma_pkg::res_t res;

  assign s1_move   = s1_vld_r && core_rdy;
  assign in_tready = !s1_vld_r || core_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_evt_r.op        <= in_tuser;
      s1_evt_r.now_ms    <= in_tdata[31:0];
      s1_evt_r.driver_ok <= in_tdata[32];
      s1_evt_r.read_ok   <= in_tdata[33];
      s1_evt_r.temp_in   <= in_tdata[48:34];
      s1_evt_r.humid_in  <= in_tdata[62:49];
    end
  end

  sma_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sma_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .evt_vld (s1_vld_r),
    .evt     (s1_evt_r),
    .evt_rdy (core_rdy),
    .res_vld (out_tvalid),
    .res     (res),
    .res_rdy (out_tready)
  );

  assign out_tdata = {6'd0, res.alarm_out, res.humid_out, res.temp_out,
                      res.op_ok, res.fsm_state};

  `SMA_ASSERT_NEXT(a_accept_fills_s1, in_tvalid && in_tready, s1_vld_r)
  `SMA_ASSERT_NEXT(a_move_gives_result, s1_move, out_tvalid)
  `SMA_ASSERT_IMPL(a_full_stall_blocks, s1_vld_r && out_tvalid && !out_tready, !in_tready)

endmodule

`default_nettype wire
